/* hw/rtl/gbnsw_pkg.sv */
// Shared types and constants for the go-back-N sender window.
`timescale 1ns / 1ps

package gbnsw_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int IDX_W       = 16;
    localparam int OP_W        = 2;
    localparam int WS_W        = 6;
    localparam int CFG_DATA_W  = 16;
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    localparam logic CFG_WINDOW_SIZE  = 1'b0;
    localparam logic CFG_TOTAL_PACKETS = 1'b1;

    localparam logic [WS_W-1:0] WINDOW_SIZE_RST = 6'd4;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_FILL,
        ACT_RESEND
    } act_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic final_word;
    } dp_stat_t;

endpackage

/* hw/rtl/go_back_n_sender_window.sv */
// Top level of the go-back-N sender window.
//
//  Channel  Direction  Handshake                Payload
//  s_       in         s_tvalid / s_tready      s_tuser: operation; s_tdata: ack_number
//  m_       out        m_tvalid / m_tready      m_tuser: send_valid; m_tdata: send_index,
//                                               transfer_done; m_tlast: last
//  cfg_     in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each item is accepted, then the window bounds are loaded, then the single-index
// send loop emits its result words (1 to 32 per item), one index per word.
// Synchronous active-low reset; no clearing pass. Configuration is always ready.
// A stall on m_tready holds the send loop; the next item is taken while the
// final word still waits in the output register.
`timescale 1ns / 1ps

module go_back_n_sender_window import gbnsw_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] ack_number
    input  logic [OP_W-1:0]        s_tuser,   // [1:0] operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] send_index, [16] transfer_done
    output logic                   m_tuser,   // [0] send_valid
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    gbnsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbnsw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_ack    (s_tdata[IDX_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* hw/rtl/gbnsw_dp.sv */
// Datapath: window state, configuration registers, send cursor and output register.
`timescale 1ns / 1ps

module gbnsw_dp import gbnsw_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [OP_W-1:0]        in_op,
    input  logic [IDX_W-1:0]       in_ack,
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    logic [WS_W-1:0]  window_size_reg, window_size_next;
    logic [IDX_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0] send_ptr_reg, send_ptr_next;
    logic             active_reg, active_next;
    act_t             act_reg, act_next;
    logic [IDX_W:0]   cur_reg, cur_next;
    logic [IDX_W:0]   end_reg, end_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_send_reg, out_send_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic             out_done_reg, out_done_next;
    logic             out_last_reg, out_last_next;

    logic [IDX_W:0]   eff_win, base_ext, total_ext, win_top, limit;
    logic             has_more, last_one, out_free;

    // window size 0 behaves as 1, anything above the maximum as the maximum
    always_comb begin
        if (window_size_reg == '0) begin
            eff_win = (IDX_W+1)'(1);
        end else if ((IDX_W+1)'(window_size_reg) > (IDX_W+1)'(WINDOW_MAX)) begin
            eff_win = (IDX_W+1)'(WINDOW_MAX);
        end else begin
            eff_win = (IDX_W+1)'(window_size_reg);
        end
    end

    assign base_ext  = {1'b0, base_reg};
    assign total_ext = {1'b0, total_reg};
    assign win_top   = base_ext + eff_win;
    assign limit     = (win_top < total_ext) ? win_top : total_ext;

    assign has_more = cur_reg < end_reg;
    assign last_one = ((cur_reg + (IDX_W+1)'(1)) >= end_reg)
                   || (cnt_reg == CNT_W'(WINDOW_MAX - 1));
    assign out_free = !out_valid_reg || m_tready;

    assign stat.out_free   = out_free;
    assign stat.final_word = !has_more || last_one;

    always_comb begin
        window_size_next = window_size_reg;
        total_next       = total_reg;
        base_next        = base_reg;
        send_ptr_next    = send_ptr_reg;
        active_next      = active_reg;
        act_next         = act_reg;
        cur_next         = cur_reg;
        end_next         = end_reg;
        cnt_next         = cnt_reg;
        done_next        = done_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_send_next    = out_send_reg;
        out_index_next   = out_index_reg;
        out_done_next    = out_done_reg;
        out_last_next    = out_last_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW_SIZE:   window_size_next = cfg_data[WS_W-1:0];
                CFG_TOTAL_PACKETS: total_next = cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end

        if (cmd.accept) begin
            case (in_op)
                OP_START: begin
                    base_next     = '0;
                    send_ptr_next = '0;
                    active_next   = 1'b1;
                    act_next      = ACT_FILL;
                end
                OP_ACK: begin
                    if (active_reg && (in_ack > base_reg)) begin
                        // acks past what was sent saturate
                        base_next = (in_ack < send_ptr_reg) ? in_ack : send_ptr_reg;
                        act_next  = ACT_FILL;
                    end else begin
                        act_next = ACT_NONE;
                    end
                end
                OP_TIMEOUT: begin
                    act_next = active_reg ? ACT_RESEND : ACT_NONE;
                end
                default: act_next = ACT_NONE;
            endcase
        end

        if (cmd.load) begin
            case (act_reg)
                ACT_FILL: begin
                    cur_next = {1'b0, send_ptr_reg};
                    end_next = limit;
                end
                ACT_RESEND: begin
                    cur_next = base_ext;
                    end_next = {1'b0, send_ptr_reg};
                end
                default: begin
                    cur_next = '0;
                    end_next = '0;
                end
            endcase
            cnt_next  = '0;
            done_next = base_ext >= total_ext;
            if (base_ext >= total_ext) begin
                active_next = 1'b0;
            end
        end

        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_send_next  = has_more;
            out_index_next = has_more ? cur_reg[IDX_W-1:0] : '0;
            out_done_next  = done_reg;
            out_last_next  = !has_more || last_one;
            if (has_more) begin
                cur_next = cur_reg + (IDX_W+1)'(1);
                cnt_next = cnt_reg + CNT_W'(1);
                if (act_reg == ACT_FILL) begin
                    send_ptr_next = cur_reg[IDX_W-1:0] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WINDOW_SIZE_RST;
            total_reg       <= '0;
            base_reg        <= '0;
            send_ptr_reg    <= '0;
            active_reg      <= 1'b0;
            act_reg         <= ACT_NONE;
            cur_reg         <= '0;
            end_reg         <= '0;
            cnt_reg         <= '0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            window_size_reg <= window_size_next;
            total_reg       <= total_next;
            base_reg        <= base_next;
            send_ptr_reg    <= send_ptr_next;
            active_reg      <= active_next;
            act_reg         <= act_next;
            cur_reg         <= cur_next;
            end_reg         <= end_next;
            cnt_reg         <= cnt_next;
            done_reg        <= done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_send_reg  <= out_send_next;
        out_index_reg <= out_index_next;
        out_done_reg  <= out_done_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_send_reg;
    assign m_tdata  = {(OUT_TDATA_W-IDX_W-1)'(0), out_done_reg, out_index_reg};

    a_ptr_above_base: assert property (@(posedge aclk) disable iff (!aresetn)
        send_ptr_reg >= base_reg)
        else $error("send pointer fell below window base");

    a_in_flight_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, send_ptr_reg} - base_ext) <= (IDX_W+1)'(WINDOW_MAX))
        else $error("more packets in flight than the window maximum");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("output word overwritten while stalled");

endmodule

/* hw/rtl/gbnsw_ctrl.sv */
// Controller: sequences accept, window load and per-word emission.
`timescale 1ns / 1ps

module gbnsw_ctrl import gbnsw_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    always_comb begin
        cmd.accept = s_tready_reg && s_tvalid;
        cmd.load   = (state_reg == ST_LOAD);
        cmd.emit   = (state_reg == ST_EMIT) && stat.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_EMIT;
            ST_EMIT: if (stat.out_free && stat.final_word) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

    a_ready_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready_reg == (state_reg == ST_IDLE))
        else $error("input ready out of step with controller state");

    a_accept_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> cmd.load)
        else $error("accepted word not followed by window load");

endmodule

/* bench/tb_go_back_n_sender_window.sv */
// Self-checking testbench for the go-back-N sender window: directed and random items.
`timescale 1ns / 1ps

module tb_go_back_n_sender_window;
    import gbnsw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
        logic             done;
        logic             is_last;
    } send_word_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]        s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = CFG_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    go_back_n_sender_window dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // window state as the block should hold it
    logic [WS_W-1:0]  win_reg   = WINDOW_SIZE_RST;
    logic [IDX_W-1:0] total_reg = '0;
    int               base_q    = 0;
    int               next_q    = 0;
    logic             active_q  = 1'b0;

    send_word_t sends_due[$];

    int snd_idle = 29;
    int rcv_idle = 73;
    int stall_req = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int n_start = 0, n_ack = 0, n_timeout = 0, n_other = 0;
    int n_words = 0, n_sends = 0, n_reg_writes = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int eff_window();
        int w;
        w = int'(win_reg);
        if (w < 1) w = 1;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        return w;
    endfunction

    task automatic predict_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] ack);
        int   idx_q[$];
        int   lim;
        int   i;
        logic do_fill;
        logic done;
        send_word_t w;
        do_fill = 1'b0;
        case (op)
            OP_START: begin
                base_q = 0;
                next_q = 0;
                active_q = 1'b1;
                do_fill = 1'b1;
                n_start++;
            end
            OP_ACK: begin
                n_ack++;
                if (active_q && int'(ack) > base_q) begin
                    base_q = (int'(ack) < next_q) ? int'(ack) : next_q;
                    do_fill = 1'b1;
                end
            end
            OP_TIMEOUT: begin
                n_timeout++;
                if (active_q)
                    for (i = base_q; i < next_q && idx_q.size() < WINDOW_MAX; i++)
                        idx_q = {idx_q, i};
            end
            default: n_other++;
        endcase
        if (do_fill) begin
            lim = base_q + eff_window();
            if (lim > int'(total_reg)) lim = int'(total_reg);
            while (next_q < lim && idx_q.size() < WINDOW_MAX) begin
                idx_q = {idx_q, next_q};
                next_q++;
            end
        end
        done = (base_q >= int'(total_reg));
        if (active_q && done) active_q = 1'b0;
        if (idx_q.size() == 0) begin
            w = '{valid: 1'b0, index: '0, done: done, is_last: 1'b1};
            sends_due = {sends_due, w};
        end
        for (i = 0; i < idx_q.size(); i++) begin
            w = '{valid: 1'b1, index: IDX_W'(idx_q[i]), done: done,
                  is_last: (i == idx_q.size() - 1)};
            sends_due = {sends_due, w};
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] ack);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_TDATA_W'(ack);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(op, ack);
    endtask

    // lets the block drain completely before registers change
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sends_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] tot);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WINDOW_SIZE;
        cfg_data  <= win;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        win_reg = win[WS_W-1:0];
        cfg_index <= CFG_TOTAL_PACKETS;
        cfg_data  <= tot;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        total_reg = tot[IDX_W-1:0];
        cfg_valid <= 1'b0;
        n_reg_writes += 2;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // receiver: random backpressure plus a long hold when a test requests one
    always @(posedge aclk) begin
        if (stall_req > 0) begin
            stall_left = stall_req;
            stall_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    send_word_t got_w, want_w;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_w = '{valid: m_tuser, index: m_tdata[IDX_W-1:0], done: m_tdata[IDX_W],
                      is_last: m_tlast};
            n_words++;
            if (got_w.valid) n_sends++;
            if (sends_due.size() == 0) begin
                report_mismatch("word with nothing pending, send_index",
                                int'(got_w.index), -1);
            end else begin
                want_w = sends_due.pop_front();
                if (got_w.valid !== want_w.valid)
                    report_mismatch("send_valid", int'(got_w.valid), int'(want_w.valid));
                if (got_w.index !== want_w.index)
                    report_mismatch("send_index", int'(got_w.index), int'(want_w.index));
                if (got_w.done !== want_w.done)
                    report_mismatch("transfer_done", int'(got_w.done), int'(want_w.done));
                if (got_w.is_last !== want_w.is_last)
                    report_mismatch("tlast", int'(got_w.is_last), int'(want_w.is_last));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("go_back_n_sender_window test failed");
            $finish;
        end
    end

    // ack, timeout and unknown op with no transfer open; empty transfer
    task automatic test_idle_ops();
        send_item(OP_ACK, 16'd5);
        send_item(OP_TIMEOUT, 16'd0);
        send_item(OP_UNUSED, 16'hFFFF);
        send_item(OP_START, 16'd0);
        send_item(OP_ACK, 16'd1);
        wait_idle();
    endtask

    task automatic test_window_extremes();
        set_regs(16'd0, 16'd3);             // zero window behaves as one
        send_item(OP_START, 16'd0);
        send_item(OP_ACK, 16'd1);
        send_item(OP_TIMEOUT, 16'd0);
        send_item(OP_ACK, 16'd3);           // beyond sent count, clamps
        send_item(OP_ACK, 16'd3);
        wait_idle();
        set_regs(16'h003F, 16'hFFFF);       // oversized window clamps to max
        send_item(OP_START, 16'd0);
        send_item(OP_ACK, 16'hFFFF);
        send_item(OP_TIMEOUT, 16'd0);
        send_item(OP_ACK, 16'd0);
        send_item(OP_START, 16'd0);         // restart mid-transfer
        wait_idle();
    endtask

    task automatic test_config_change();
        set_regs(16'h0050, 16'd40);         // upper bits of window dropped
        send_item(OP_START, 16'd0);
        send_item(OP_ACK, 16'd9);
        wait_idle();
        set_regs(16'd2, 16'd40);            // shrink: nothing new until base catches up
        send_item(OP_ACK, 16'd11);
        send_item(OP_TIMEOUT, 16'd0);
        wait_idle();
        set_regs(16'd8, 16'd10);            // total below what was already sent
        send_item(OP_ACK, 16'd12);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        set_regs(16'd32, 16'd1000);
        stall_req = HOLD_CYCLES;
        send_item(OP_START, 16'd0);
        send_item(OP_TIMEOUT, 16'd0);
        send_item(OP_TIMEOUT, 16'd0);
        send_item(OP_ACK, 16'd20);
        send_item(OP_TIMEOUT, 16'd0);
        send_item(OP_TIMEOUT, 16'd0);
        wait_idle();
    endtask

    task automatic random_regs();
        logic [CFG_DATA_W-1:0] win, tot;
        case ($urandom_range(5))
            0:       win = 16'd0;
            1:       win = CFG_DATA_W'($urandom_range(33, 63));
            2:       win = 16'd32;
            default: win = CFG_DATA_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(7))
            0:       tot = 16'hFFFF;
            1:       tot = CFG_DATA_W'($urandom);
            2:       tot = 16'd0;
            default: tot = CFG_DATA_W'($urandom_range(1, 80));
        endcase
        set_regs(win, tot);
    endtask

    task automatic test_random(input int n_items);
        int               done_cnt;
        int               r;
        int               span;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] ack;
        logic             ignored;
        done_cnt = 0;
        random_regs();
        while (done_cnt < n_items) begin
            r = $urandom_range(99);
            ack = IDX_W'($urandom);
            if ((!active_q && r < 85) || r < 8) begin
                op = OP_START;
            end else if (r < 70) begin
                op = OP_ACK;
                span = next_q - base_q + 2;
                case ($urandom_range(9))
                    7:       ack = IDX_W'($urandom);
                    8:       ack = IDX_W'(base_q);
                    9:       ack = 16'hFFFF;
                    default: ack = IDX_W'(base_q + int'($urandom_range(1, span)));
                endcase
            end else if (r < 93) begin
                op = OP_TIMEOUT;
            end else begin
                op = OP_UNUSED;
            end
            ignored = (op == OP_UNUSED) || (op != OP_START && !active_q) ||
                      (op == OP_ACK && int'(ack) <= base_q);
            send_item(op, ack);
            if (!ignored) done_cnt++;
            if (done_cnt % 12 == 11 && !ignored) begin
                wait_idle();
                random_regs();
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_ops();
        test_window_extremes();
        test_config_change();

        test_random(30);
        snd_idle = 73;
        rcv_idle = 29;
        test_random(30);
        snd_idle = 0;
        rcv_idle = 0;
        test_random(30);
        test_backpressure();

        $display("Ran %0d items: %0d starts, %0d acks, %0d timeouts, %0d unknown ops.",
                 n_start + n_ack + n_timeout + n_other, n_start, n_ack, n_timeout, n_other);
        $display("Checked %0d words (%0d packet sends) across %0d register writes.",
                 n_words, n_sends, n_reg_writes);
        if (mismatches == 0) begin
            $display("go_back_n_sender_window test passed");
        end else begin
            $display("go_back_n_sender_window test failed");
        end
        $finish;
    end

endmodule
